FILE: src/rope_pkg.sv
// package for the rotary position embedding block: types, codes and constant tables
`default_nettype none
package rope_pkg;

    localparam int unsigned CHAN_MAX = 256;
    localparam int unsigned PAIR_MAX = CHAN_MAX / 2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIM_SMALL = 2'd1;
    localparam logic [1:0] ST_DIM_ODD   = 2'd2;
    localparam logic [1:0] ST_IDX_RANGE = 2'd3;

    // register indexes
    localparam logic [1:0] REG_CHAN_CNT   = 2'd0;
    localparam logic [1:0] REG_LOG2_THETA = 2'd1;
    localparam logic [1:0] REG_POS_MULT   = 2'd2;

    localparam logic [8:0]  CHAN_CNT_RST   = 9'd128;
    localparam logic [21:0] LOG2_THETA_RST = 22'd870827;
    localparam logic [23:0] POS_MULT_RST   = 24'd65536;
    localparam logic [23:0] POS_MULT_UNIT  = 24'd65536;

    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
    localparam logic [30:0]        ONE_Q30_U  = 31'd1073741824;
    localparam logic [29:0]        INV_TWO_PI = 30'd683565276;
    localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;

    localparam int unsigned DIV_CELLS = 30;
    localparam int unsigned EXP_CELLS = 16;
    localparam int unsigned ROT_CELLS = 30;

    typedef struct packed {
        logic signed [31:0] x_even;
        logic signed [31:0] x_odd;
        logic [6:0]         pair_index;
        logic [23:0]        position;
    } in_t;

    typedef struct packed {
        logic signed [31:0] y_even;
        logic signed [31:0] y_odd;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic signed [31:0] x_even;
        logic signed [31:0] x_odd;
        logic [1:0]         status;
    } side_t;

    typedef struct packed {
        logic [8:0]  rem;
        logic [29:0] num;
        logic [29:0] quo;
        logic [47:0] peff;
    } div_t;

    typedef struct packed {
        logic [30:0] acc;
        logic [15:0] frac;
        logic [13:0] ipart;
        logic [47:0] peff;
    } exp_t;

    typedef struct packed {
        logic signed [31:0] cos_acc;
        logic signed [31:0] sin_acc;
        logic [29:0]        phase_bits;
        logic [1:0]         quad;
    } rot_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // restoring long division
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // factor 2^(-2^-k) in Q30
    function automatic logic [29:0] exp_factor(input int k);
        logic [63:0] d;
        d = 64'd1 << 29;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) begin
                d = isqrt64(d << 30);
            end
        end
        return d[29:0];
    endfunction

    // half-angle unit rotation {cos, sin} in Q30 after the given step
    function automatic logic [61:0] rot_factor(input int step);
        logic [63:0] c;
        logic [63:0] s;
        c = '0;
        s = 64'd1 << 30;
        for (int j = 0; j < 30; j++) begin
            if (j <= step) begin
                c = isqrt64(((64'd1 << 30) + c) << 29);
                if (c != 64'd0) begin
                    s = udiv64(s << 29, c);
                end
            end
        end
        return {c[30:0], s[30:0]};
    endfunction

endpackage
`default_nettype wire

FILE: src/rope_div_cell.sv
// one bit of the restoring divider that forms the frequency exponent
`default_nettype none
module rope_div_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [8:0]       divisor,
    input  wire logic             in_valid,
    input  wire rope_pkg::side_t  in_side,
    input  wire rope_pkg::div_t   in_data,
    output logic                  out_valid,
    output rope_pkg::side_t       out_side,
    output rope_pkg::div_t        out_data
);
    logic            valid_reg;
    rope_pkg::side_t side_reg;
    rope_pkg::div_t  data_reg;
    rope_pkg::div_t  data_next;
    logic [9:0]      rem_w;
    logic [9:0]      rem_diff;
    logic            ge;

    assign rem_w    = {in_data.rem, in_data.num[29]};
    assign ge       = rem_w >= {1'b0, divisor};
    assign rem_diff = rem_w - {1'b0, divisor};

    always_comb begin
        data_next      = in_data;
        data_next.rem  = ge ? rem_diff[8:0] : rem_w[8:0];
        data_next.num  = {in_data.num[28:0], 1'b0};
        data_next.quo  = {in_data.quo[28:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

FILE: src/rope_exp_cell.sv
// one factor of the fractional power of two
`default_nettype none
module rope_exp_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [29:0]      factor,
    input  wire logic             in_valid,
    input  wire rope_pkg::side_t  in_side,
    input  wire rope_pkg::exp_t   in_data,
    output logic                  out_valid,
    output rope_pkg::side_t       out_side,
    output rope_pkg::exp_t        out_data
);
    logic            valid_reg;
    rope_pkg::side_t side_reg;
    rope_pkg::exp_t  data_reg;
    rope_pkg::exp_t  data_next;
    logic [60:0]     prod;

    assign prod = 61'(in_data.acc) * 61'(factor);

    always_comb begin
        data_next      = in_data;
        data_next.acc  = in_data.frac[15] ? prod[60:30] : in_data.acc;
        data_next.frac = {in_data.frac[14:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

FILE: src/rope_rot_cell.sv
// one half-angle rotation step: products, then combine
`default_nettype none
module rope_rot_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [30:0]      c_k,
    input  wire logic [30:0]      s_k,
    input  wire logic             in_valid,
    input  wire rope_pkg::side_t  in_side,
    input  wire rope_pkg::rot_t   in_data,
    output logic                  out_valid,
    output rope_pkg::side_t       out_side,
    output rope_pkg::rot_t        out_data
);
    logic signed [31:0] c_s;
    logic signed [31:0] s_s;

    logic               a_valid_reg;
    rope_pkg::side_t    a_side_reg;
    rope_pkg::rot_t     a_data_reg;
    logic               a_bit_reg;
    logic signed [63:0] p_cc_reg;
    logic signed [63:0] p_ss_reg;
    logic signed [63:0] p_cs_reg;
    logic signed [63:0] p_sc_reg;

    logic               b_valid_reg;
    rope_pkg::side_t    b_side_reg;
    rope_pkg::rot_t     b_data_reg;
    rope_pkg::rot_t     b_data_next;
    rope_pkg::rot_t     a_data_next;
    logic signed [63:0] cos_sum;
    logic signed [63:0] sin_sum;
    logic signed [63:0] cos_shr;
    logic signed [63:0] sin_shr;

    assign c_s = signed'({1'b0, c_k});
    assign s_s = signed'({1'b0, s_k});

    always_comb begin
        a_data_next            = in_data;
        a_data_next.phase_bits = {in_data.phase_bits[28:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= in_side;
            a_data_reg <= a_data_next;
            a_bit_reg  <= in_data.phase_bits[29];
            p_cc_reg   <= 64'(in_data.cos_acc) * 64'(c_s);
            p_ss_reg   <= 64'(in_data.sin_acc) * 64'(s_s);
            p_cs_reg   <= 64'(in_data.cos_acc) * 64'(s_s);
            p_sc_reg   <= 64'(in_data.sin_acc) * 64'(c_s);
            b_side_reg <= a_side_reg;
            b_data_reg <= b_data_next;
        end
    end

    assign cos_sum = p_cc_reg - p_ss_reg;
    assign sin_sum = p_cs_reg + p_sc_reg;
    assign cos_shr = cos_sum >>> 30;
    assign sin_shr = sin_sum >>> 30;

    always_comb begin
        b_data_next = a_data_reg;
        if (a_bit_reg) begin
            b_data_next.cos_acc = cos_shr[31:0];
            b_data_next.sin_acc = sin_shr[31:0];
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign out_data  = b_data_reg;
endmodule
`default_nettype wire

FILE: src/rotary_position_embedding.sv
// rotary position embedding of one interleaved channel pair per request
// Usage:
//   s_valid/s_ready/s_data take one channel pair with its pair index and
//   token position. m_valid/m_ready/m_data return the rotated pair, rounded
//   and saturated to Q16.16, with a status code. A bad head size or an index
//   out of range returns the pair unchanged with its status.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the head size, log2_theta and
//   pos_multiplier; cfg_ready is always high, writes belong to idle time.
// Throughput: one request per cycle while not stalled. The path is a
//   30-cell divider for the exponent, 16 cells for the fractional power
//   of two, a split 48x47 phase multiply and 30 two-stage half-angle
//   rotation cells, then the output multiply and saturation.
// Stall: when the result register holds a result that is not taken, the
//   whole pipeline holds and s_ready drops; it rises as soon as the result
//   is taken or the result register is empty.
// Reset: all pipeline valid flags clear and the registers return to
//   head size 128, log2_theta 870827, pos_multiplier 65536.
`default_nettype none
module rotary_position_embedding (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire rope_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output rope_pkg::out_t       m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data
);
    logic        en;
    logic [8:0]  chan_cnt_reg;
    logic [21:0] log2_theta_reg;
    logic [23:0] pos_mult_reg;

    // stage 0
    logic            st0_valid_reg;
    rope_pkg::side_t st0_side_reg;
    rope_pkg::div_t  st0_div_reg;
    rope_pkg::side_t st0_side_next;
    rope_pkg::div_t  st0_div_next;
    logic [23:0]     pm_eff;
    logic [28:0]     idx_theta;

    logic            div_valid [0:rope_pkg::DIV_CELLS];
    rope_pkg::side_t div_side  [0:rope_pkg::DIV_CELLS];
    rope_pkg::div_t  div_data  [0:rope_pkg::DIV_CELLS];

    logic            exp_valid [0:rope_pkg::EXP_CELLS];
    rope_pkg::side_t exp_side  [0:rope_pkg::EXP_CELLS];
    rope_pkg::exp_t  exp_data  [0:rope_pkg::EXP_CELLS];

    // frequency and phase stages
    logic            v_valid_reg;
    rope_pkg::side_t v_side_reg;
    logic [60:0]     v_val_reg;
    logic [13:0]     v_ipart_reg;
    logic [47:0]     v_peff_reg;
    logic [14:0]     shift_amt;
    logic [46:0]     inv_next;
    logic            sh_valid_reg;
    rope_pkg::side_t sh_side_reg;
    logic [46:0]     sh_inv_reg;
    logic [47:0]     sh_peff_reg;
    logic            pp_valid_reg;
    rope_pkg::side_t pp_side_reg;
    logic [47:0]     pp_ll_reg;
    logic [46:0]     pp_lh_reg;
    logic [47:0]     pp_hl_reg;
    logic [46:0]     pp_hh_reg;
    logic            sum_valid_reg;
    rope_pkg::side_t sum_side_reg;
    logic [63:0]     sum_a_reg;
    logic [63:0]     sum_b_reg;
    logic [63:0]     sum_total;
    logic            ph_valid_reg;
    rope_pkg::side_t ph_side_reg;
    logic [31:0]     phase_reg;

    logic            rot_valid [0:rope_pkg::ROT_CELLS];
    rope_pkg::side_t rot_side  [0:rope_pkg::ROT_CELLS];
    rope_pkg::rot_t  rot_data  [0:rope_pkg::ROT_CELLS];

    // quadrant, output multiply, result
    logic               q_valid_reg;
    rope_pkg::side_t    q_side_reg;
    logic signed [31:0] q_cos_reg;
    logic signed [31:0] q_sin_reg;
    logic signed [31:0] q_cos_next;
    logic signed [31:0] q_sin_next;
    logic               f_valid_reg;
    rope_pkg::side_t    f_side_reg;
    logic signed [63:0] f_ec_reg;
    logic signed [63:0] f_os_reg;
    logic signed [63:0] f_es_reg;
    logic signed [63:0] f_oc_reg;
    logic               out_valid_reg;
    rope_pkg::out_t     out_reg;
    rope_pkg::out_t     out_next;

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
        logic signed [63:0] y;
        logic signed [31:0] r;
        y = (acc + rope_pkg::ROUND_HALF) >>> 30;
        if (y > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (y < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = y[31:0];
        end
        return r;
    endfunction

    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg   <= rope_pkg::CHAN_CNT_RST;
            log2_theta_reg <= rope_pkg::LOG2_THETA_RST;
            pos_mult_reg   <= rope_pkg::POS_MULT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rope_pkg::REG_CHAN_CNT:   chan_cnt_reg   <= cfg_data[8:0];
                rope_pkg::REG_LOG2_THETA: log2_theta_reg <= cfg_data[21:0];
                rope_pkg::REG_POS_MULT:   pos_mult_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // stage 0: checks, effective position, dividend
    assign pm_eff    = (pos_mult_reg == '0) ? rope_pkg::POS_MULT_UNIT : pos_mult_reg;
    assign idx_theta = 29'(s_data.pair_index) * 29'(log2_theta_reg);

    always_comb begin
        st0_side_next.x_even = s_data.x_even;
        st0_side_next.x_odd  = s_data.x_odd;
        priority if (chan_cnt_reg < 9'd2) begin
            st0_side_next.status = rope_pkg::ST_DIM_SMALL;
        end else if (chan_cnt_reg[0]) begin
            st0_side_next.status = rope_pkg::ST_DIM_ODD;
        end else if ({1'b0, s_data.pair_index} >= chan_cnt_reg[8:1]
                     || 32'(s_data.pair_index) >= rope_pkg::PAIR_MAX) begin
            st0_side_next.status = rope_pkg::ST_IDX_RANGE;
        end else begin
            st0_side_next.status = rope_pkg::ST_OK;
        end
        st0_div_next.rem  = '0;
        st0_div_next.num  = {idx_theta, 1'b0};
        st0_div_next.quo  = '0;
        st0_div_next.peff = 48'(s_data.position) * 48'(pm_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (en) begin
            st0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_side_reg <= st0_side_next;
            st0_div_reg  <= st0_div_next;
        end
    end

    // exponent divider
    assign div_valid[0] = st0_valid_reg;
    assign div_side[0]  = st0_side_reg;
    assign div_data[0]  = st0_div_reg;

    for (genvar g = 0; g < rope_pkg::DIV_CELLS; g++) begin : g_div
        rope_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .divisor   (chan_cnt_reg),
            .in_valid  (div_valid[g]),
            .in_side   (div_side[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_side  (div_side[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // fractional power of two
    assign exp_valid[0]      = div_valid[rope_pkg::DIV_CELLS];
    assign exp_side[0]       = div_side[rope_pkg::DIV_CELLS];
    assign exp_data[0].acc   = rope_pkg::ONE_Q30_U;
    assign exp_data[0].frac  = div_data[rope_pkg::DIV_CELLS].quo[15:0];
    assign exp_data[0].ipart = div_data[rope_pkg::DIV_CELLS].quo[29:16];
    assign exp_data[0].peff  = div_data[rope_pkg::DIV_CELLS].peff;

    for (genvar g = 0; g < rope_pkg::EXP_CELLS; g++) begin : g_exp
        localparam logic [29:0] FACTOR = rope_pkg::exp_factor(g + 1);
        rope_exp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .factor    (FACTOR),
            .in_valid  (exp_valid[g]),
            .in_side   (exp_side[g]),
            .in_data   (exp_data[g]),
            .out_valid (exp_valid[g+1]),
            .out_side  (exp_side[g+1]),
            .out_data  (exp_data[g+1])
        );
    end

    // inverse frequency and phase
    assign shift_amt = {1'b0, v_ipart_reg} + 15'd14;
    assign inv_next  = (shift_amt >= 15'd64) ? '0 : 47'(v_val_reg >> shift_amt[5:0]);
    assign sum_total = sum_a_reg + sum_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_valid_reg   <= 1'b0;
            sh_valid_reg  <= 1'b0;
            pp_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            ph_valid_reg  <= 1'b0;
        end else if (en) begin
            v_valid_reg   <= exp_valid[rope_pkg::EXP_CELLS];
            sh_valid_reg  <= v_valid_reg;
            pp_valid_reg  <= sh_valid_reg;
            sum_valid_reg <= pp_valid_reg;
            ph_valid_reg  <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_side_reg   <= exp_side[rope_pkg::EXP_CELLS];
            v_val_reg    <= 61'(exp_data[rope_pkg::EXP_CELLS].acc) * 61'(rope_pkg::INV_TWO_PI);
            v_ipart_reg  <= exp_data[rope_pkg::EXP_CELLS].ipart;
            v_peff_reg   <= exp_data[rope_pkg::EXP_CELLS].peff;
            sh_side_reg  <= v_side_reg;
            sh_inv_reg   <= inv_next;
            sh_peff_reg  <= v_peff_reg;
            pp_side_reg  <= sh_side_reg;
            pp_ll_reg    <= 48'(sh_peff_reg[23:0]) * 48'(sh_inv_reg[23:0]);
            pp_lh_reg    <= 47'(sh_peff_reg[23:0]) * 47'(sh_inv_reg[46:24]);
            pp_hl_reg    <= 48'(sh_peff_reg[47:24]) * 48'(sh_inv_reg[23:0]);
            pp_hh_reg    <= 47'(sh_peff_reg[47:24]) * 47'(sh_inv_reg[46:24]);
            sum_side_reg <= pp_side_reg;
            sum_a_reg    <= 64'(pp_ll_reg) + (64'(pp_lh_reg) << 24);
            sum_b_reg    <= (64'(pp_hl_reg) << 24) + (64'(pp_hh_reg) << 48);
            ph_side_reg  <= sum_side_reg;
            phase_reg    <= sum_total[63:32];
        end
    end

    // half-angle rotation chain
    assign rot_valid[0]           = ph_valid_reg;
    assign rot_side[0]            = ph_side_reg;
    assign rot_data[0].cos_acc    = rope_pkg::ONE_Q30;
    assign rot_data[0].sin_acc    = '0;
    assign rot_data[0].phase_bits = phase_reg[29:0];
    assign rot_data[0].quad       = phase_reg[31:30];

    for (genvar g = 0; g < rope_pkg::ROT_CELLS; g++) begin : g_rot
        localparam logic [61:0] CS = rope_pkg::rot_factor(g);
        rope_rot_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .c_k       (CS[61:31]),
            .s_k       (CS[30:0]),
            .in_valid  (rot_valid[g]),
            .in_side   (rot_side[g]),
            .in_data   (rot_data[g]),
            .out_valid (rot_valid[g+1]),
            .out_side  (rot_side[g+1]),
            .out_data  (rot_data[g+1])
        );
    end

    // quadrant fold
    always_comb begin
        unique case (rot_data[rope_pkg::ROT_CELLS].quad)
            2'd0: begin
                q_cos_next = rot_data[rope_pkg::ROT_CELLS].cos_acc;
                q_sin_next = rot_data[rope_pkg::ROT_CELLS].sin_acc;
            end
            2'd1: begin
                q_cos_next = -rot_data[rope_pkg::ROT_CELLS].sin_acc;
                q_sin_next = rot_data[rope_pkg::ROT_CELLS].cos_acc;
            end
            2'd2: begin
                q_cos_next = -rot_data[rope_pkg::ROT_CELLS].cos_acc;
                q_sin_next = -rot_data[rope_pkg::ROT_CELLS].sin_acc;
            end
            default: begin
                q_cos_next = rot_data[rope_pkg::ROT_CELLS].sin_acc;
                q_sin_next = -rot_data[rope_pkg::ROT_CELLS].cos_acc;
            end
        endcase
    end

    // rotate the pair, round, saturate, or pass it through
    always_comb begin
        out_next.status = f_side_reg.status;
        if (f_side_reg.status == rope_pkg::ST_OK) begin
            out_next.y_even = round_sat(f_ec_reg - f_os_reg);
            out_next.y_odd  = round_sat(f_es_reg + f_oc_reg);
        end else begin
            out_next.y_even = f_side_reg.x_even;
            out_next.y_odd  = f_side_reg.x_odd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            q_valid_reg   <= rot_valid[rope_pkg::ROT_CELLS];
            f_valid_reg   <= q_valid_reg;
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_side_reg <= rot_side[rope_pkg::ROT_CELLS];
            q_cos_reg  <= q_cos_next;
            q_sin_reg  <= q_sin_next;
            f_side_reg <= q_side_reg;
            f_ec_reg   <= 64'(q_side_reg.x_even) * 64'(q_cos_reg);
            f_os_reg   <= 64'(q_side_reg.x_odd) * 64'(q_sin_reg);
            f_es_reg   <= 64'(q_side_reg.x_even) * 64'(q_sin_reg);
            f_oc_reg   <= 64'(q_side_reg.x_odd) * 64'(q_cos_reg);
            out_reg    <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // an empty result register never blocks a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("s_ready low with empty result register");

    // only a well-formed head size lets a request through with status ok
    a_ok_needs_dim: assert property (@(posedge aclk) disable iff (!aresetn)
        st0_valid_reg && st0_side_reg.status == rope_pkg::ST_OK
        |-> chan_cnt_reg >= 9'd2 && !chan_cnt_reg[0])
        else $error("status ok with bad head size");

    // a head size write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == rope_pkg::REG_CHAN_CNT
        |=> chan_cnt_reg == $past(cfg_data[8:0]))
        else $error("head size write lost");

    // a held result keeps the tail stage frozen
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(f_valid_reg) && $stable(f_side_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire
